// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds, consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/ifrl_pkg.sv =====
// types, codes and helpers for the ipv4 route lookup block
`default_nettype none

package ifrl_pkg;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_HEADER = 1'b1;

    // header word positions of interest
    localparam int WORD_TTL    = 4;
    localparam int WORD_CSUM   = 5;
    localparam int WORD_DST_HI = 8;
    localparam int WORD_DST_LO = 9;

    localparam int ADDR_W     = 32;
    localparam int PLEN_W     = 6;
    localparam int HWORD_W    = 16;
    localparam int TTL_W      = 8;
    localparam logic [PLEN_W-1:0] PLEN_FULL = 6'd32;

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_LOCAL   = 2'd1,
        VERDICT_TTL     = 2'd2,
        VERDICT_NOROUTE = 2'd3
    } t_verdict;

    typedef struct packed {
        logic                operation;
        logic [ADDR_W-1:0]   route_prefix;
        logic [PLEN_W-1:0]   route_prefix_len;
        logic [ADDR_W-1:0]   route_gateway;
        logic [HWORD_W-1:0]  header_word;
        logic                header_last;
    } t_cmd;

    typedef struct packed {
        t_verdict            verdict;
        logic [ADDR_W-1:0]   next_hop;
        logic [TTL_W-1:0]    new_ttl;
        logic [HWORD_W-1:0]  new_checksum;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]   prefix;
        logic [PLEN_W-1:0]   prefix_len;
        logic [ADDR_W-1:0]   gateway;
    } t_route_entry;

    // lengths above 32 behave as 32, zero gives an empty mask
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len >= PLEN_FULL) begin
            mask = '1;
        end else begin
            mask = ~({ADDR_W{1'b1}} >> len[4:0]);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ifrl_route_table.sv =====
// route table memory, one write port and one registered read port
`default_nettype none

module ifrl_route_table #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_wr_en,
    input  wire logic [IW-1:0]           i_wr_addr,
    input  wire ifrl_pkg::t_route_entry  i_wr_entry,
    input  wire logic [IW-1:0]           i_rd_addr,
    output ifrl_pkg::t_route_entry       o_rd_entry
);

    ifrl_pkg::t_route_entry r_mem [DEPTH];
    ifrl_pkg::t_route_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_entry <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

`default_nettype wire

// ===== hdl/ipv4_forward_route_lookup.sv =====
// ipv4 forwarding decision: route table, header capture and checksum update
`default_nettype none

// Commands enter on i_cmd, taken at a clock edge where start is high and busy low.
// An add command writes the next free route entry; adds to a full table are
// dropped. Header commands carry one 16-bit header word each and are taken one
// per cycle. The word marked last raises busy and starts the decision: ttl and
// local address are checked in ST_CHECK, then the table is walked one entry
// per cycle through the single read port of the table memory.
// ST_CHECK decides ttl expired, local delivery or an empty table; the walk
// ends on a match at an entry or with no route after the last entry. busy
// falls when the result shows. Each result comes with o_strobe high for
// exactly one cycle and stays on o_result until the next result; the
// receiver cannot stall it. local_address is written on the cfg channel, which
// is ready while the block is idle. Reset empties the table, clears the header
// progress and sets local_address to zero; no clearing pass is needed.
module ipv4_forward_route_lookup #(
    parameter int TABLE_DEPTH      = 16,
    parameter int MAX_HEADER_WORDS = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ifrl_pkg::t_cmd     i_cmd,
    output logic                    o_strobe,
    output ifrl_pkg::t_result       o_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = $clog2(MAX_HEADER_WORDS + 1);
    localparam int SW = ifrl_pkg::HWORD_W + PW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_count;
    logic [PW-1:0]                   r_pos;
    logic [SW-1:0]                   r_sum;
    logic [ifrl_pkg::TTL_W-1:0]      r_ttl;
    logic [ifrl_pkg::ADDR_W-1:0]     r_dest;
    logic [ifrl_pkg::ADDR_W-1:0]     r_local;
    logic [IW-1:0]                   r_idx;
    logic                            r_strobe;
    ifrl_pkg::t_result               r_result;

    logic                            s_accept;
    logic                            s_wr_en;
    ifrl_pkg::t_route_entry          s_wr_entry;
    logic [IW-1:0]                   s_rd_addr;
    ifrl_pkg::t_route_entry          s_entry;
    logic [ifrl_pkg::ADDR_W-1:0]     s_mask;
    logic                            s_hit;
    logic [CW-1:0]                   s_idx_next;
    logic [SW-1:0]                   s_sum_adj;
    logic [16:0]                     s_fold1;
    logic [15:0]                     s_fold2;
    ifrl_pkg::t_result               s_fwd;
    logic                            s_done;
    ifrl_pkg::t_result               s_res;

    assign s_accept    = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    // table writes only happen while idle and read data is only used while busy, so the
    // busy interlock keeps them apart
    assign s_wr_en = s_accept && (i_cmd.operation == ifrl_pkg::OP_ADD)
                     && (r_count < CW'(TABLE_DEPTH));
    assign s_wr_entry.prefix     = i_cmd.route_prefix;
    assign s_wr_entry.prefix_len = i_cmd.route_prefix_len;
    assign s_wr_entry.gateway    = i_cmd.route_gateway;

    // read one entry ahead of the compare
    assign s_rd_addr = (r_state == ST_WALK) ? IW'(r_idx + 1'b1) : '0;

    ifrl_route_table #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (s_wr_en),
        .i_wr_addr  (r_count[IW-1:0]),
        .i_wr_entry (s_wr_entry),
        .i_rd_addr  (s_rd_addr),
        .o_rd_entry (s_entry)
    );

    assign s_mask     = ifrl_pkg::prefix_mask(s_entry.prefix_len);
    assign s_hit      = ((s_entry.prefix & s_mask) == (r_dest & s_mask));
    assign s_idx_next = CW'(r_idx) + 1'b1;

    // ttl word was summed before decrement, take one off its high byte
    assign s_sum_adj = r_sum - SW'(256);
    assign s_fold1   = {1'b0, s_sum_adj[15:0]} + 17'(s_sum_adj[SW-1:16]);
    assign s_fold2   = s_fold1[15:0] + 16'(s_fold1[16]);

    assign s_fwd.verdict      = ifrl_pkg::VERDICT_FORWARD;
    assign s_fwd.next_hop     = s_entry.gateway;
    assign s_fwd.new_ttl      = r_ttl - 1'b1;
    assign s_fwd.new_checksum = ~s_fold2;

    // decision outcome of the current cycle
    always_comb begin
        s_done = 1'b0;
        s_res  = '0;
        case (r_state)
            ST_CHECK: begin
                s_done = 1'b1;
                if (r_ttl == '0) begin
                    s_res.verdict = ifrl_pkg::VERDICT_TTL;
                end else if (r_dest == r_local) begin
                    s_res.verdict = ifrl_pkg::VERDICT_LOCAL;
                end else if (r_count == '0) begin
                    s_res.verdict = ifrl_pkg::VERDICT_NOROUTE;
                end else begin
                    s_done = 1'b0;
                end
            end
            ST_WALK: begin
                if (s_hit) begin
                    s_done = 1'b1;
                    s_res  = s_fwd;
                end else if (s_idx_next == r_count) begin
                    s_done        = 1'b1;
                    s_res.verdict = ifrl_pkg::VERDICT_NOROUTE;
                end
            end
            default: begin
                s_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_pos    <= '0;
            r_sum    <= '0;
            r_ttl    <= '0;
            r_dest   <= '0;
            r_local  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            r_result <= '0;
        end else begin
            r_strobe <= s_done;
            if (s_done) begin
                r_result <= s_res;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_local <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_wr_en) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (s_accept && (i_cmd.operation == ifrl_pkg::OP_HEADER)) begin
                        if (r_pos < PW'(MAX_HEADER_WORDS)) begin
                            if (r_pos == PW'(ifrl_pkg::WORD_TTL)) begin
                                r_ttl <= i_cmd.header_word[15:8];
                            end
                            if (r_pos == PW'(ifrl_pkg::WORD_DST_HI)) begin
                                r_dest[31:16] <= i_cmd.header_word;
                            end
                            if (r_pos == PW'(ifrl_pkg::WORD_DST_LO)) begin
                                r_dest[15:0] <= i_cmd.header_word;
                            end
                            if (r_pos != PW'(ifrl_pkg::WORD_CSUM)) begin
                                r_sum <= r_sum + SW'(i_cmd.header_word);
                            end
                            r_pos <= r_pos + 1'b1;
                        end
                        if (i_cmd.header_last) begin
                            r_state <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    r_idx <= '0;
                    if (s_done) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    r_idx <= IW'(r_idx + 1'b1);
                    if (s_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // packet done: drop the header progress
            if (s_done) begin
                r_pos  <= '0;
                r_sum  <= '0;
                r_ttl  <= '0;
                r_dest <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ifrl_checker.sv =====
// port-level checks for the ipv4 route lookup block, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module ifrl_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire ifrl_pkg::t_cmd     i_cmd,
    input wire logic               o_strobe,
    input wire ifrl_pkg::t_result  o_result,
    input wire logic               o_cfg_ready
);

    logic s_last_taken;
    logic s_non_fwd;
    logic s_fwd_fields_zero;

    assign s_last_taken = start && !busy && (i_cmd.operation == ifrl_pkg::OP_HEADER)
                          && i_cmd.header_last;
    assign s_non_fwd    = o_strobe && (o_result.verdict != ifrl_pkg::VERDICT_FORWARD);
    assign s_fwd_fields_zero = (o_result.next_hop == '0) && (o_result.new_ttl == '0)
                               && (o_result.new_checksum == '0);

    // a verdict only follows a decision cycle
    `ASSERT_SAME(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ASSERT_NEXT(a_last_sets_busy, i_clk, i_rst_n, s_last_taken, busy)
    `ASSERT_SAME(a_non_fwd_zero, i_clk, i_rst_n, s_non_fwd, s_fwd_fields_zero)
    `ASSERT_SAME(a_cfg_ready_idle, i_clk, i_rst_n, o_cfg_ready, !busy)

endmodule

bind ipv4_forward_route_lookup ifrl_checker u_ifrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_strobe    (o_strobe),
    .o_result    (o_result),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
